>>> rtl/psl_pkg.sv
// Shared types, register indexes and constants of the pitch-shift loop controller.
package psl_pkg;

  // Request payload: one audio sample's event flags.
  typedef struct packed {
    logic crossing_pulse;
    logic attack_pulse;
  } psl_in_t;

  // Result payload: tap delays, crossfade gains, latency, live tap and event flags.
  typedef struct packed {
    logic [31:0] first_tap_delay;
    logic [31:0] second_tap_delay;
    logic [16:0] first_gain;
    logic [16:0] second_gain;
    logic [31:0] latency;
    logic        loop_fired;
    logic        live_tap;
    logic        bailout_fired;
  } psl_out_t;

  // Configuration register indexes.
  typedef enum logic [3:0] {
    REG_PITCH_RATIO   = 4'd0,
    REG_LOWER_THRESH  = 4'd1,
    REG_UPPER_THRESH  = 4'd2,
    REG_LONG_PERIOD   = 4'd3,
    REG_SHORT_PERIOD  = 4'd4,
    REG_LOOP_FADE     = 4'd5,
    REG_ATTACK_FADE   = 4'd6,
    REG_BAILOUT_FADE  = 4'd7
  } psl_reg_e;

  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 32;

  // Divider operand widths.
  localparam int unsigned DivDvdW = 49;
  localparam int unsigned DivDvsW = 32;

  localparam logic [16:0] OneQ16 = 17'h10000;
  localparam logic [15:0] RatioLo = 16'd6554;
  localparam logic [15:0] RatioHi = 16'd64880;

  // Playback times are 48-bit modular values.
  localparam int unsigned TimeW = 48;

  // True when the modular difference a - b is zero or negative.
  function automatic logic time_le0(input logic [TimeW-1:0] a, input logic [TimeW-1:0] b);
    logic [TimeW-1:0] d;
    d = a - b;
    return (d == '0) || d[TimeW-1];
  endfunction

endpackage

>>> rtl/pitch_shift_loop_controller.sv
// Top level of the pitch-shift loop controller: sequencer, crossing ring and result register.
//
// One request per audio sample. A request with no gain step to compute and no crossing
// passes from the idle state through the loop, attack and done states. A fade step that
// needs a new gain adds a gain division; the last step of a fade adds none. A crossing
// adds a playback-time division, a prune check and the decision, plus a ring read and a
// check per entry pruned. A loop search then reads and checks up to HISTORY_DEPTH entries:
// one rejected on its playback time goes no further, one rejected on the delay or time
// difference test first takes a product, and one that reaches the period test waits on
// both divisions; a closing read state follows when no entry fits. The 49-step radix-2
// divider and the one-read-per-cycle crossing ring pace these steps. The ring is a
// synchronous memory; its entries are only read below the fill count, so it needs no
// clearing pass after reset. A finished result waits in an output register; the sequencer
// holds in its last state only while an earlier result there is still unaccepted.
module pitch_shift_loop_controller
  import psl_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 16,
  parameter int unsigned MIN_DELAY = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  psl_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output psl_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AddrW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CntW  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SumW  = AddrW + 2;
  localparam logic [31:0] MinDelayQ = 32'(MIN_DELAY) << 16;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'h0001,
    ST_FDIV   = 13'h0002,
    ST_LOOP   = 13'h0004,
    ST_ATK    = 13'h0008,
    ST_PTDIV  = 13'h0010,
    ST_PRD    = 13'h0020,
    ST_PCK    = 13'h0040,
    ST_DECIDE = 13'h0080,
    ST_SRD    = 13'h0100,
    ST_SCK    = 13'h0200,
    ST_SMUL   = 13'h0400,
    ST_SDIV   = 13'h0800,
    ST_DONE   = 13'h1000
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [15:0] ratio_q, lower_q, upper_q, loop_len_q, atk_len_q, bail_len_q;
  logic [31:0] long_lim_q, short_lim_q;

  // Block state
  logic [31:0] sample_q;
  logic [31:0] tap_q [2];
  logic [16:0] gain_q [2];
  logic        cur_q, fading_q, pend_q;
  logic [15:0] elapsed_q, fade_len_q;
  logic [TimeW-1:0] fire_q;
  logic [AddrW-1:0] head_q;
  logic [CntW-1:0]  count_q;

  // Per-request work registers
  logic        crossing_q, attack_q, loop_ev_q, bail_ev_q;
  logic [31:0] di_q;
  logic [TimeW-1:0] pt_q, rec_q;
  logic [62:0] prod_q;
  logic [AddrW-1:0] start_q;
  logic [CntW-1:0]  idx_q;
  logic        out_valid_q;
  psl_out_t    out_q;

  // Crossing ring
  logic [TimeW-1:0] ring_mem [HISTORY_DEPTH];
  logic [TimeW-1:0] rd_q;
  logic             ring_we, ring_re;
  logic [AddrW-1:0] ring_raddr;

  // Divider ports
  logic               div_start_a, div_start_b, busy_a, busy_b;
  logic [DivDvdW-1:0] dvd_a, dvd_b, quo_a, quo_b;
  logic [DivDvsW-1:0] dvs_a, dvs_b;

  // Derived values
  logic             inc;
  logic             in_fire;
  logic [TimeW-1:0] now;
  logic [16:0]      dd;
  logic [32:0]      sum0, sum1;
  logic [16:0]      el_new;
  logic [SumW-1:0]  old_sum;
  logic [AddrW-1:0] oldest;
  logic [AddrW:0]   srch_sum;
  logic [AddrW-1:0] srch_addr;
  logic [TimeW-1:0] pt_new, tuf, pd, fire_gap;
  logic [31:0]      lp, sp, nd;
  logic [16:0]      t_gain;
  logic             bf_en, bf_set;
  logic [15:0]      bf_len;
  logic [15:0]      cfg_ratio;

  assign inc     = ~cur_q;
  assign in_fire = in_valid_i && in_ready_o;
  assign now     = {sample_q, 16'h0000};
  assign dd      = OneQ16 - {1'b0, ratio_q};
  assign sum0    = {1'b0, tap_q[0]} + {16'h0000, dd};
  assign sum1    = {1'b0, tap_q[1]} + {16'h0000, dd};
  assign el_new  = {1'b0, elapsed_q} + 17'd1;

  // Locate the oldest live entry and the entry under search.
  always_comb begin
    old_sum = SumW'(head_q) + SumW'(HISTORY_DEPTH) - SumW'(count_q);
    if (old_sum >= SumW'(HISTORY_DEPTH)) begin
      old_sum = old_sum - SumW'(HISTORY_DEPTH);
    end
    oldest = old_sum[AddrW-1:0];
    srch_sum = {1'b0, start_q} + (AddrW+1)'(idx_q);
    if (srch_sum >= (AddrW+1)'(HISTORY_DEPTH)) begin
      srch_sum = srch_sum - (AddrW+1)'(HISTORY_DEPTH);
    end
    srch_addr = srch_sum[AddrW-1:0];
  end

  assign pt_new   = now + quo_a[TimeW-1:0];
  assign tuf      = rd_q - now;
  assign pd       = pt_q - rec_q;
  // Now minus fire time; negative while the loop point lies ahead.
  assign fire_gap = now - fire_q;
  assign lp     = (long_lim_q == '0) ? 32'd1 : long_lim_q;
  assign sp     = (short_lim_q == '0) ? 32'd1 : short_lim_q;
  assign nd     = (prod_q[47:16] < MinDelayQ) ? MinDelayQ : prod_q[47:16];
  assign t_gain = {1'b0, quo_a[15:0]};
  assign cfg_ratio = (cfg_data_i[15:0] < RatioLo) ? RatioLo :
                     ((cfg_data_i[15:0] > RatioHi) ? RatioHi : cfg_data_i[15:0]);

  // Select which fade to begin in this cycle.
  always_comb begin
    bf_en  = 1'b0;
    bf_set = 1'b0;
    bf_len = loop_len_q;
    unique case (state_q)
      ST_LOOP: begin
        if (pend_q && !fire_gap[TimeW-1]) begin
          bf_en  = 1'b1;
          bf_len = loop_len_q;
        end
      end
      ST_ATK: begin
        if (attack_q) begin
          bf_en  = 1'b1;
          bf_set = 1'b1;
          bf_len = atk_len_q;
        end
      end
      ST_DECIDE: begin
        if (!fading_q && !pend_q && (di_q > {upper_q, 16'h0000})) begin
          bf_en  = 1'b1;
          bf_set = 1'b1;
          bf_len = bail_len_q;
        end
      end
      default: begin
        bf_en = 1'b0;
      end
    endcase
  end

  // Drive the dividers.
  always_comb begin
    div_start_a = 1'b0;
    div_start_b = 1'b0;
    dvd_a = DivDvdW'({el_new[15:0], 16'h0000});
    dvs_a = {16'h0000, fade_len_q};
    dvd_b = DivDvdW'(pd);
    dvs_b = sp;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && fading_q && (el_new < {1'b0, fade_len_q})) begin
          div_start_a = 1'b1;
        end
      end
      ST_ATK: begin
        if (crossing_q) begin
          div_start_a = 1'b1;
          dvd_a = DivDvdW'({tap_q[cur_q], 16'h0000});
          dvs_a = {16'h0000, ratio_q};
        end
      end
      ST_SMUL: begin
        dvd_a = DivDvdW'(pd) + DivDvdW'(lp) - DivDvdW'(1);
        dvs_a = lp;
        if ((prod_q < {15'h0000, tap_q[cur_q], 16'h0000}) && !time_le0(pt_q, rec_q)) begin
          div_start_a = 1'b1;
          div_start_b = 1'b1;
        end
      end
      default: begin
        div_start_a = 1'b0;
      end
    endcase
  end

  psl_divider u_div_a (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_a),
    .dividend_i (dvd_a),
    .divisor_i  (dvs_a),
    .busy_o     (busy_a),
    .quotient_o (quo_a)
  );

  psl_divider u_div_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_b),
    .dividend_i (dvd_b),
    .divisor_i  (dvs_b),
    .busy_o     (busy_b),
    .quotient_o (quo_b)
  );

  // Ring read and write controls.
  assign ring_we = (state_q == ST_PTDIV) && !busy_a;
  always_comb begin
    ring_re    = 1'b0;
    ring_raddr = oldest;
    if (state_q == ST_PRD && count_q != '0) begin
      ring_re = 1'b1;
    end else if (state_q == ST_SRD && idx_q != count_q) begin
      ring_re    = 1'b1;
      ring_raddr = srch_addr;
    end
  end

  // Crossing ring memory.
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[head_q] <= pt_new;
    end
    if (ring_re) begin
      rd_q <= ring_mem[ring_raddr];
    end
  end

  // Work registers with no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      crossing_q <= in_data_i.crossing_pulse;
      attack_q   <= in_data_i.attack_pulse;
    end
    if (state_q == ST_ATK) begin
      di_q <= tap_q[cur_q];
    end
    if (ring_we) begin
      pt_q <= pt_new;
    end
    if (state_q == ST_SCK) begin
      rec_q  <= rd_q;
      prod_q <= tuf[46:0] * ratio_q;
    end
    if (state_q == ST_DECIDE) begin
      start_q <= oldest;
    end
  end

  // Sequencer and block state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ratio_q     <= 16'd32768;
      lower_q     <= 16'd960;
      upper_q     <= 16'd2400;
      long_lim_q  <= 32'd157286400;
      short_lim_q <= 32'd6291456;
      loop_len_q  <= 16'd480;
      atk_len_q   <= 16'd96;
      bail_len_q  <= 16'd1920;
      sample_q    <= '0;
      tap_q[0]    <= MinDelayQ;
      tap_q[1]    <= MinDelayQ;
      gain_q[0]   <= OneQ16;
      gain_q[1]   <= '0;
      cur_q       <= 1'b0;
      fading_q    <= 1'b0;
      elapsed_q   <= '0;
      fade_len_q  <= 16'd1;
      pend_q      <= 1'b0;
      fire_q      <= '0;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      loop_ev_q   <= 1'b0;
      bail_ev_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // Load a finished result or drop one that was taken.
      if ((state_q == ST_DONE) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            sample_q  <= sample_q + 32'd1;
            tap_q[0]  <= sum0[32] ? 32'hFFFF_FFFF : sum0[31:0];
            tap_q[1]  <= sum1[32] ? 32'hFFFF_FFFF : sum1[31:0];
            loop_ev_q <= 1'b0;
            bail_ev_q <= 1'b0;
            state_q   <= ST_LOOP;
            if (fading_q) begin
              elapsed_q <= el_new[15:0];
              if (el_new >= {1'b0, fade_len_q}) begin
                cur_q         <= inc;
                gain_q[inc]   <= OneQ16;
                gain_q[cur_q] <= '0;
                fading_q      <= 1'b0;
              end else begin
                state_q <= ST_FDIV;
              end
            end
          end
        end
        ST_FDIV: begin
          if (!busy_a) begin
            gain_q[inc]   <= t_gain;
            gain_q[cur_q] <= OneQ16 - t_gain;
            state_q       <= ST_LOOP;
          end
        end
        ST_LOOP: begin
          if (bf_en) begin
            loop_ev_q <= 1'b1;
            pend_q    <= 1'b0;
          end
          state_q <= ST_ATK;
        end
        ST_ATK: begin
          if (attack_q) begin
            pend_q  <= 1'b0;
            head_q  <= '0;
            count_q <= '0;
          end
          state_q <= crossing_q ? ST_PTDIV : ST_DONE;
        end
        ST_PTDIV: begin
          if (!busy_a) begin
            head_q <= (head_q == AddrW'(HISTORY_DEPTH - 1)) ? '0 : head_q + 1'b1;
            if (count_q != CntW'(HISTORY_DEPTH)) begin
              count_q <= count_q + 1'b1;
            end
            state_q <= ST_PRD;
          end
        end
        ST_PRD: begin
          state_q <= (count_q == '0) ? ST_DECIDE : ST_PCK;
        end
        ST_PCK: begin
          if (time_le0(rd_q, now)) begin
            count_q <= count_q - 1'b1;
            state_q <= ST_PRD;
          end else begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          state_q <= ST_DONE;
          if (bf_en) begin
            head_q    <= '0;
            count_q   <= '0;
            bail_ev_q <= 1'b1;
          end else if (!fading_q && !pend_q && (di_q > {lower_q, 16'h0000})) begin
            idx_q   <= '0;
            state_q <= ST_SRD;
          end
        end
        ST_SRD: begin
          state_q <= (idx_q == count_q) ? ST_DONE : ST_SCK;
        end
        ST_SCK: begin
          if (time_le0(rd_q, now)) begin
            idx_q   <= idx_q + 1'b1;
            state_q <= ST_SRD;
          end else begin
            state_q <= ST_SMUL;
          end
        end
        ST_SMUL: begin
          if (div_start_a) begin
            state_q <= ST_SDIV;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= ST_SRD;
          end
        end
        ST_SDIV: begin
          if (!busy_a && !busy_b) begin
            if ((quo_a != '0) && (quo_a <= quo_b)) begin
              tap_q[inc] <= nd;
              fire_q     <= rec_q;
              pend_q     <= 1'b1;
              state_q    <= ST_DONE;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= ST_SRD;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.first_tap_delay  <= tap_q[0];
            out_q.second_tap_delay <= tap_q[1];
            out_q.first_gain       <= gain_q[0];
            out_q.second_gain      <= gain_q[1];
            out_q.latency          <= tap_q[cur_q];
            out_q.loop_fired       <= loop_ev_q;
            out_q.live_tap         <= cur_q;
            out_q.bailout_fired    <= bail_ev_q;
            state_q                <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // Begin a crossfade toward the idle tap.
      if (bf_en) begin
        if (bf_set) begin
          tap_q[inc] <= MinDelayQ;
        end
        if (!fading_q) begin
          gain_q[cur_q] <= OneQ16;
        end
        gain_q[inc] <= '0;
        fading_q    <= 1'b1;
        elapsed_q   <= '0;
        fade_len_q  <= (bf_len == '0) ? 16'd1 : bf_len;
      end

      // Apply configuration writes.
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PITCH_RATIO: begin
            ratio_q <= cfg_ratio;
            head_q  <= '0;
            count_q <= '0;
            pend_q  <= 1'b0;
          end
          REG_LOWER_THRESH: lower_q     <= cfg_data_i[15:0];
          REG_UPPER_THRESH: upper_q     <= cfg_data_i[15:0];
          REG_LONG_PERIOD:  long_lim_q  <= cfg_data_i;
          REG_SHORT_PERIOD: short_lim_q <= cfg_data_i;
          REG_LOOP_FADE:    loop_len_q  <= cfg_data_i[15:0];
          REG_ATTACK_FADE:  atk_len_q   <= cfg_data_i[15:0];
          REG_BAILOUT_FADE: bail_len_q  <= cfg_data_i[15:0];
          default: begin
            ratio_q <= ratio_q;
          end
        endcase
      end
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/psl_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module psl_divider
  import psl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivDvdW-1:0] dividend_i,
  input  logic [DivDvsW-1:0] divisor_i,
  output logic               busy_o,
  output logic [DivDvdW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DivDvdW + 1);

  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [DivDvdW-1:0] quo_q, quo_d;
  logic [DivDvsW-1:0] rem_q, rem_d;
  logic [DivDvsW-1:0] dvs_q, dvs_d;
  logic [DivDvsW:0]   trial;
  logic [DivDvsW:0]   diff;

  // Shift in one dividend bit and try to subtract the divisor.
  always_comb begin
    trial = {rem_q, quo_q[DivDvdW-1]};
    diff  = trial - {1'b0, dvs_q};
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    if (start_i) begin
      cnt_d = CntW'(DivDvdW);
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (!diff[DivDvsW]) begin
        rem_d = diff[DivDvsW-1:0];
        quo_d = {quo_q[DivDvdW-2:0], 1'b1};
      end else begin
        rem_d = trial[DivDvsW-1:0];
        quo_d = {quo_q[DivDvdW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Hold operands and partial results.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

endmodule
